[sv/omni_pkg.sv]
// Shared constants and types for the omni wheel kinematics pipeline.
package omni_pkg;

  localparam int ENC_BITS = 13;
  localparam int VEL_BITS = 16;
  localparam int ARM_BITS = 16;
  localparam int RATIO_BITS = 24;
  localparam int RPM_BITS = 16;

  localparam int ANGLE_BITS_DEF = 13;
  localparam int SINE_FRAC_DEF = 15;

  // Rotated velocity and wheel sum widths (Q18.0 and Q20.16)
  localparam int ROT_W = 18;
  localparam int LIN_W = 36;

  localparam int SINE_STAGES = 8;
  localparam int WHEEL_STAGES = 3;
  localparam int PIPE_STAGES = 1 + SINE_STAGES + 3 + WHEEL_STAGES;

  // Odd Taylor terms of sin(pi/2 * x), Q1.30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172273;

  localparam logic [1:0] CFG_YAW_CENTER = 2'd0;
  localparam logic [1:0] CFG_ARM_LENGTH = 2'd1;
  localparam logic [1:0] CFG_RPM_RATIO = 2'd2;

  typedef logic signed [VEL_BITS-1:0] vel_t;
  typedef logic [ENC_BITS-1:0] enc_t;
  typedef logic signed [RPM_BITS-1:0] rpm_t;
  typedef logic signed [LIN_W-1:0] lin_t;

endpackage

[sv/omni_wheel_field_oriented_kinematics.sv]
// Four-wheel omni inverse kinematics with yaw field rotation, top level.
//
//   channel | signals                                  | direction
//   in      | in_valid, in_stall, func, vel_x/y/w, yaw | into block
//   out     | out_valid, out_stall, wheel0..3_rpm, clip | out of block
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// One item per cycle unless out_stall holds a full pipeline; the stages are the
// angle index, the 8-stage Horner sine pipeline, rotation and the split 36x24 wheel multiply.
// Reset clears the stage valid bits and the three config registers.
// A stage holds only when it and every later stage are full, so bubbles
// close up and the input keeps flowing while a result waits.
module omni_wheel_field_oriented_kinematics #(
  parameter int ANGLE_BITS = omni_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRACTION_BITS = omni_pkg::SINE_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  omni_pkg::vel_t                  vel_x,
  input  omni_pkg::vel_t                  vel_y,
  input  omni_pkg::vel_t                  vel_w,
  input  omni_pkg::enc_t                  yaw_encoder,
  output logic                            out_valid,
  input  logic                            out_stall,
  output omni_pkg::rpm_t                  wheel0_rpm,
  output omni_pkg::rpm_t                  wheel1_rpm,
  output omni_pkg::rpm_t                  wheel2_rpm,
  output omni_pkg::rpm_t                  wheel3_rpm,
  output logic                            clipped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [omni_pkg::RATIO_BITS-1:0] cfg_data
);
  import omni_pkg::*;

  localparam int F = SINE_FRACTION_BITS;
  localparam int N = PIPE_STAGES;
  localparam int ROT_STAGE = 1 + SINE_STAGES;
  localparam int WHEEL_STAGE = ROT_STAGE + 3;
  localparam int PW = VEL_BITS + F + 1;
  localparam int SW = PW + 1;
  localparam int WW = VEL_BITS + ARM_BITS + 1;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);

  // config
  enc_t yaw_center;
  logic [ARM_BITS-1:0] arm_length;
  logic [RATIO_BITS-1:0] rpm_ratio;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_center <= '0;
      arm_length <= '0;
      rpm_ratio  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_YAW_CENTER: yaw_center <= cfg_data[ENC_BITS-1:0];
        CFG_ARM_LENGTH: arm_length <= cfg_data[ARM_BITS-1:0];
        CFG_RPM_RATIO:  rpm_ratio  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid chain and stage enables
  logic [N-1:0] v;
  logic [N-1:0] en;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      en[k] = !out_stall || !(&(v | ((N'(1) << k) - N'(1))));
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: angle index
  enc_t d;
  logic [ANGLE_BITS-1:0] idx_in;
  logic [ANGLE_BITS-1:0] idx_s, idx_c;
  logic func1;
  vel_t vx1, vy1, vw1;

  always_comb begin
    d = yaw_encoder - yaw_center;
    idx_in = ANGLE_BITS'((32'(d) << ANGLE_BITS) >> ENC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      idx_s <= idx_in;
      idx_c <= idx_in + QUARTER;
      func1 <= func;
      vx1   <= vel_x;
      vy1   <= vel_y;
      vw1   <= vel_w;
    end
  end

  // sine and cosine
  logic signed [F:0] sin9, cos9;

  omni_sine #(
    .ANGLE_BITS(ANGLE_BITS),
    .SINE_FRACTION_BITS(SINE_FRACTION_BITS)
  ) u_sin (
    .clk(clk),
    .en(en[SINE_STAGES:1]),
    .idx(idx_s),
    .val(sin9)
  );

  omni_sine #(
    .ANGLE_BITS(ANGLE_BITS),
    .SINE_FRACTION_BITS(SINE_FRACTION_BITS)
  ) u_cos (
    .clk(clk),
    .en(en[SINE_STAGES:1]),
    .idx(idx_c),
    .val(cos9)
  );

  // command delay line alongside the sine pipeline
  logic func_d [SINE_STAGES];
  vel_t vx_d [SINE_STAGES];
  vel_t vy_d [SINE_STAGES];
  vel_t vw_d [SINE_STAGES];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      func_d[0] <= func1;
      vx_d[0]   <= vx1;
      vy_d[0]   <= vy1;
      vw_d[0]   <= vw1;
    end
    for (int k = 1; k < SINE_STAGES; k++) begin
      if (en[k+1]) begin
        func_d[k] <= func_d[k-1];
        vx_d[k]   <= vx_d[k-1];
        vy_d[k]   <= vy_d[k-1];
        vw_d[k]   <= vw_d[k-1];
      end
    end
  end

  // rotation products
  logic signed [PW-1:0] pxc, pys, pxs, pyc;
  logic signed [VEL_BITS+ARM_BITS:0] wt10, wt11;
  logic func10;
  vel_t vx10, vy10;

  always_ff @(posedge clk) begin
    if (en[ROT_STAGE]) begin
      pxc    <= PW'(vx_d[SINE_STAGES-1]) * PW'(cos9);
      pys    <= PW'(vy_d[SINE_STAGES-1]) * PW'(sin9);
      pxs    <= PW'(vx_d[SINE_STAGES-1]) * PW'(sin9);
      pyc    <= PW'(vy_d[SINE_STAGES-1]) * PW'(cos9);
      wt10   <= WW'(vw_d[SINE_STAGES-1]) * WW'($signed({1'b0, arm_length}));
      func10 <= func_d[SINE_STAGES-1];
      vx10   <= vx_d[SINE_STAGES-1];
      vy10   <= vy_d[SINE_STAGES-1];
    end
  end

  // rotated velocity, floor after rounding bias
  logic signed [SW-1:0] sx, sy;
  logic signed [ROT_W-1:0] vxr, vyr;

  always_comb begin
    sx = SW'(pxc) - SW'(pys) + HALF;
    sy = SW'(pxs) + SW'(pyc) + HALF;
  end

  always_ff @(posedge clk) begin
    if (en[ROT_STAGE+1]) begin
      vxr  <= func10 ? ROT_W'(sx >>> F) : ROT_W'(vx10);
      vyr  <= func10 ? ROT_W'(sy >>> F) : ROT_W'(vy10);
      wt11 <= wt10;
    end
  end

  // wheel sums in Q20.16
  lin_t px, py, wt;
  lin_t lin [4];

  always_comb begin
    px = LIN_W'(vxr) <<< 16;
    py = LIN_W'(vyr) <<< 16;
    wt = LIN_W'(wt11);
  end

  always_ff @(posedge clk) begin
    if (en[ROT_STAGE+2]) begin
      lin[0] <= px + py + wt;
      lin[1] <= px - py + wt;
      lin[2] <= -px - py + wt;
      lin[3] <= -px + py + wt;
    end
  end

  rpm_t rpm [4];
  logic [3:0] clip;

  for (genvar i = 0; i < 4; i++) begin : g_wheel
    omni_wheel u_wheel (
      .clk(clk),
      .en(en[WHEEL_STAGE+WHEEL_STAGES-1:WHEEL_STAGE]),
      .lin(lin[i]),
      .ratio(rpm_ratio),
      .rpm(rpm[i]),
      .clip(clip[i])
    );
  end

  assign wheel0_rpm = rpm[0];
  assign wheel1_rpm = rpm[1];
  assign wheel2_rpm = rpm[2];
  assign wheel3_rpm = rpm[3];
  assign clipped    = |clip;

endmodule

[sv/omni_sine.sv]
// Pipelined quarter-wave sine: mirror, square, Horner steps, scale and sign.
module omni_sine #(
  parameter int ANGLE_BITS = omni_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRACTION_BITS = omni_pkg::SINE_FRAC_DEF
) (
  input  logic                           clk,
  input  logic [omni_pkg::SINE_STAGES-1:0] en,
  input  logic [ANGLE_BITS-1:0]          idx,
  output logic signed [SINE_FRACTION_BITS:0] val
);
  import omni_pkg::*;

  localparam int F = SINE_FRACTION_BITS;
  localparam int P7W = 23;
  localparam int P5W = 27;
  localparam int P3W = 30;
  localparam int P1W = 31;
  localparam logic [31:0] ROUND = 32'd1 << (29 - F);
  localparam logic [31:0] MAXMAG = (32'd1 << F) - 32'd1;

  logic [16:0] xr;
  logic [16:0] x2, x3, x4, x5, x6, x7;
  logic [1:0]  q2, q3, q4, q5, q6, q7, q8;
  logic [16:0] y3, y4, y5, y6;
  logic [P7W-1:0] p4;
  logic [P5W-1:0] p5;
  logic [P3W-1:0] p6;
  logic [P1W-1:0] p7;
  logic [30:0] v8;
  logic [33:0] sq;
  logic [47:0] t4, t5, t6, t7, t8;
  logic [31:0] rnd;
  logic [31:0] mfull;
  logic [F-1:0] mag;

  always_comb begin
    xr = 17'(idx[ANGLE_BITS-3:0]) << (18 - ANGLE_BITS);
    sq = 34'(x2) * 34'(x2);
    t4 = 48'(SIN_C9) * 48'(y3);
    t5 = 48'(p4) * 48'(y4);
    t6 = 48'(p5) * 48'(y5);
    t7 = 48'(p6) * 48'(y6);
    t8 = 48'(p7) * 48'(x7);
    rnd = 32'(v8) + ROUND;
    mfull = rnd >> (30 - F);
    mag = (mfull > MAXMAG) ? MAXMAG[F-1:0] : mfull[F-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q2 <= idx[ANGLE_BITS-1:ANGLE_BITS-2];
      x2 <= idx[ANGLE_BITS-2] ? (17'd65536 - xr) : xr;
    end
    if (en[1]) begin
      q3 <= q2;
      x3 <= x2;
      y3 <= 17'(sq >> 16);
    end
    if (en[2]) begin
      q4 <= q3;
      x4 <= x3;
      y4 <= y3;
      p4 <= P7W'(48'(SIN_C7) - (t4 >> 16));
    end
    if (en[3]) begin
      q5 <= q4;
      x5 <= x4;
      y5 <= y4;
      p5 <= P5W'(48'(SIN_C5) - (t5 >> 16));
    end
    if (en[4]) begin
      q6 <= q5;
      x6 <= x5;
      y6 <= y5;
      p6 <= P3W'(48'(SIN_C3) - (t6 >> 16));
    end
    if (en[5]) begin
      q7 <= q6;
      x7 <= x6;
      p7 <= P1W'(48'(SIN_C1) - (t7 >> 16));
    end
    if (en[6]) begin
      q8 <= q7;
      v8 <= 31'(t8 >> 16);
    end
    if (en[7]) begin
      // lower half turn is negative
      val <= q8[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

[sv/omni_wheel.sv]
// One wheel: split multiply by the rpm ratio, truncate toward zero, saturate.
module omni_wheel (
  input  logic                              clk,
  input  logic [omni_pkg::WHEEL_STAGES-1:0] en,
  input  omni_pkg::lin_t                    lin,
  input  logic [omni_pkg::RATIO_BITS-1:0]   ratio,
  output omni_pkg::rpm_t                    rpm,
  output logic                              clip
);
  import omni_pkg::*;

  localparam int LO_W = LIN_W / 2;
  localparam int HI_W = LIN_W - LO_W;
  localparam int PLO_W = LO_W + RATIO_BITS;
  localparam int PHI_W = HI_W + RATIO_BITS + 1;
  localparam int PROD_W = 61;
  localparam int SHIFT = 36;
  localparam int T_W = PROD_W - SHIFT;
  localparam logic signed [T_W-1:0] RPM_MAX = T_W'(32767);
  localparam logic signed [T_W-1:0] RPM_MIN = -T_W'(32768);

  logic [PLO_W-1:0] plo;
  logic signed [PHI_W-1:0] phi;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] bias;
  logic signed [PROD_W-1:0] biased;
  logic signed [T_W-1:0] t;

  always_comb begin
    // negative products round toward zero
    bias = prod[PROD_W-1] ? PROD_W'((PROD_W'(1) << SHIFT) - PROD_W'(1)) : '0;
    biased = prod + bias;
    t = T_W'(biased >>> SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo <= PLO_W'(lin[LO_W-1:0]) * PLO_W'(ratio);
      phi <= PHI_W'($signed(lin[LIN_W-1:LO_W])) * PHI_W'($signed({1'b0, ratio}));
    end
    if (en[1]) begin
      prod <= (PROD_W'(phi) <<< LO_W) + PROD_W'($signed({1'b0, plo}));
    end
    if (en[2]) begin
      if (t > RPM_MAX) begin
        rpm  <= RPM_MAX[RPM_BITS-1:0];
        clip <= 1'b1;
      end else if (t < RPM_MIN) begin
        rpm  <= RPM_MIN[RPM_BITS-1:0];
        clip <= 1'b1;
      end else begin
        rpm  <= t[RPM_BITS-1:0];
        clip <= 1'b0;
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the omni wheel kinematics pipeline: directed and random commands.
module tb_top;
  import omni_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * PIPE_STAGES + 20;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int ANGLE_MASK = (1 << ANGLE_BITS_DEF) - 1;
  localparam int QUARTER_TURN = 1 << (ANGLE_BITS_DEF - 2);
  localparam longint ROUND_HALF = longint'(1) << (SINE_FRAC_DEF - 1);

  typedef struct packed {
    logic [3:0][RPM_BITS-1:0] speed;
    logic clip;
  } wheel_set_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic func;
  vel_t vel_x;
  vel_t vel_y;
  vel_t vel_w;
  enc_t yaw_encoder;
  logic out_valid;
  logic out_stall;
  rpm_t wheel0_rpm;
  rpm_t wheel1_rpm;
  rpm_t wheel2_rpm;
  rpm_t wheel3_rpm;
  logic clipped;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [RATIO_BITS-1:0] cfg_data;

  // shadow copy of the block's registers
  enc_t center_q;
  logic [ARM_BITS-1:0] arm_q;
  logic [RATIO_BITS-1:0] ratio_q;

  wheel_set_t expected_speeds[$];
  int mismatches;
  bit sender_idle;
  bit receiver_idle;

  omni_wheel_field_oriented_kinematics dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .vel_w(vel_w),
    .yaw_encoder(yaw_encoder),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .wheel0_rpm(wheel0_rpm),
    .wheel1_rpm(wheel1_rpm),
    .wheel2_rpm(wheel2_rpm),
    .wheel3_rpm(wheel3_rpm),
    .clipped(clipped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // quarter-wave polynomial sine, signed Q1.15
  function automatic longint sine_q15(int unsigned idx);
    int unsigned quad;
    int unsigned rem;
    longint unsigned x, y, p, v, m;
    quad = (idx >> (ANGLE_BITS_DEF - 2)) & 3;
    rem = idx & (QUARTER_TURN - 1);
    x = longint'(rem) << (18 - ANGLE_BITS_DEF);
    if (quad[0]) x = 65536 - x;
    y = (x * x) >> 16;
    p = 64'(SIN_C9);
    p = 64'(SIN_C7) - ((p * y) >> 16);
    p = 64'(SIN_C5) - ((p * y) >> 16);
    p = 64'(SIN_C3) - ((p * y) >> 16);
    p = 64'(SIN_C1) - ((p * y) >> 16);
    v = (p * x) >> 16;
    m = (v + (64'd1 << (29 - SINE_FRAC_DEF))) >> (30 - SINE_FRAC_DEF);
    if (m > (64'd1 << SINE_FRAC_DEF) - 1) m = (64'd1 << SINE_FRAC_DEF) - 1;
    return quad[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic wheel_set_t predict_wheel_speeds(logic mode, vel_t vx, vel_t vy,
                                                      vel_t vw, enc_t enc);
    longint rx, ry, s, c, lin, prod, rpm;
    int unsigned idx;
    wheel_set_t res;
    res = '0;
    rx = longint'(vx);
    ry = longint'(vy);
    if (mode) begin
      idx = (int'(enc) - int'(center_q)) & ANGLE_MASK;
      s = sine_q15(idx);
      c = sine_q15((idx + QUARTER_TURN) & ANGLE_MASK);
      rx = (longint'(vx) * c - longint'(vy) * s + ROUND_HALF) >>> SINE_FRAC_DEF;
      ry = (longint'(vx) * s + longint'(vy) * c + ROUND_HALF) >>> SINE_FRAC_DEF;
    end
    for (int i = 0; i < 4; i++) begin
      // wheel i: x sign + + - -, y sign + - - +
      lin = ((i < 2) ? rx : -rx) + ((i == 1 || i == 2) ? -ry : ry);
      lin = lin * 65536 + longint'(vw) * longint'(arm_q);
      prod = lin * longint'(ratio_q);
      rpm = (prod >= 0) ? (prod >>> 36) : -((-prod) >>> 36);
      if (rpm > 32767) begin
        rpm = 32767;
        res.clip = 1'b1;
      end else if (rpm < -32768) begin
        rpm = -32768;
        res.clip = 1'b1;
      end
      res.speed[i] = rpm[RPM_BITS-1:0];
    end
    return res;
  endfunction

  function automatic vel_t random_velocity();
    case ($urandom_range(0, 5))
      0: return vel_t'(16'h7FFF);
      1: return vel_t'(16'h8000);
      2, 3: return vel_t'(int'($urandom_range(0, 4096)) - 2048);
      default: return vel_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic issue_command(logic mode, vel_t vx, vel_t vy, vel_t vw, enc_t enc);
    int gap;
    gap = sender_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = mode;
    vel_x = vx;
    vel_y = vy;
    vel_w = vw;
    yaw_encoder = enc;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_speeds.push_back(predict_wheel_speeds(mode, vx, vy, vw, enc));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_speeds.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [RATIO_BITS-1:0] data);
    wait_for_results();
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_YAW_CENTER: center_q = data[ENC_BITS-1:0];
      CFG_ARM_LENGTH: arm_q = data[ARM_BITS-1:0];
      CFG_RPM_RATIO: ratio_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // registers are zero out of reset, so every wheel reads zero
  task automatic test_reset_defaults();
    issue_command(1'b0, vel_t'(16'h7FFF), vel_t'(16'h7FFF), vel_t'(16'h7FFF), enc_t'(0));
    issue_command(1'b1, vel_t'(16'h8000), vel_t'(16'h8000), vel_t'(16'h8000), enc_t'(8191));
  endtask

  task automatic test_config_masking();
    cfg_write(CFG_YAW_CENTER, 24'hFFE005);
    cfg_write(CFG_ARM_LENGTH, 24'hA51234);
    cfg_write(CFG_RPM_RATIO, 24'h008000);
    cfg_write(CFG_UNMAPPED, 24'h5A5A5A);
    issue_command(1'b1, vel_t'(4096), vel_t'(-4096), vel_t'(2048), enc_t'(1000));
    issue_command(1'b0, vel_t'(-8192), vel_t'(300), vel_t'(-4096), enc_t'(5));
  endtask

  task automatic test_follow_extremes();
    cfg_write(CFG_ARM_LENGTH, 24'h008000);
    cfg_write(CFG_RPM_RATIO, 24'h010000);
    issue_command(1'b0, vel_t'(16'h7FFF), vel_t'(0), vel_t'(0), enc_t'(4000));
    issue_command(1'b0, vel_t'(16'h8000), vel_t'(0), vel_t'(0), enc_t'(4000));
    issue_command(1'b0, vel_t'(0), vel_t'(16'h7FFF), vel_t'(0), enc_t'(0));
    issue_command(1'b0, vel_t'(0), vel_t'(16'h8000), vel_t'(0), enc_t'(0));
    issue_command(1'b0, vel_t'(0), vel_t'(0), vel_t'(16'h7FFF), enc_t'(8191));
    issue_command(1'b0, vel_t'(-1), vel_t'(1), vel_t'(16'h8000), enc_t'(8191));
  endtask

  // quadrant edges, one count either side of center, and wrap below center
  task automatic test_rotation_quadrants();
    cfg_write(CFG_YAW_CENTER, 24'd100);
    issue_command(1'b1, vel_t'(4096), vel_t'(-2048), vel_t'(0), enc_t'(100));
    issue_command(1'b1, vel_t'(4096), vel_t'(-2048), vel_t'(0), enc_t'(100 + 2048));
    issue_command(1'b1, vel_t'(4096), vel_t'(-2048), vel_t'(0), enc_t'(100 + 4096));
    issue_command(1'b1, vel_t'(4096), vel_t'(-2048), vel_t'(0), enc_t'(100 + 6144));
    issue_command(1'b1, vel_t'(4096), vel_t'(-2048), vel_t'(0), enc_t'(101));
    issue_command(1'b1, vel_t'(4096), vel_t'(-2048), vel_t'(0), enc_t'(99));
    issue_command(1'b1, vel_t'(16'h7FFF), vel_t'(16'h8000), vel_t'(0), enc_t'(0));
    issue_command(1'b1, vel_t'(16'h8000), vel_t'(16'h7FFF), vel_t'(0), enc_t'(8191));
  endtask

  task automatic test_saturation();
    cfg_write(CFG_ARM_LENGTH, 24'h00FFFF);
    cfg_write(CFG_RPM_RATIO, 24'hFFFFFF);
    issue_command(1'b0, vel_t'(16'h7FFF), vel_t'(16'h7FFF), vel_t'(16'h7FFF), enc_t'(0));
    issue_command(1'b0, vel_t'(16'h8000), vel_t'(16'h8000), vel_t'(16'h8000), enc_t'(0));
    issue_command(1'b1, vel_t'(16'h8000), vel_t'(16'h7FFF), vel_t'(16'h8000), enc_t'(777));
  endtask

  task automatic test_random_traffic();
    logic [RATIO_BITS-1:0] center_data, arm_data, ratio_data;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          center_data = '1;
          arm_data = '1;
          ratio_data = '1;
        end
        1: begin
          center_data = '0;
          arm_data = '0;
          ratio_data = 24'd1;
        end
        default: begin
          center_data = RATIO_BITS'($urandom);
          arm_data = RATIO_BITS'($urandom);
          ratio_data = RATIO_BITS'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
        end
      endcase
      // phase 2 runs back to back on both sides
      sender_idle = (phase != 2) && ($urandom_range(0, 3) != 0);
      receiver_idle = (phase != 2) && ($urandom_range(0, 3) != 0);
      cfg_write(CFG_YAW_CENTER, center_data);
      cfg_write(CFG_ARM_LENGTH, arm_data);
      cfg_write(CFG_RPM_RATIO, ratio_data);
      if ($urandom_range(0, 1)) cfg_write(CFG_UNMAPPED, RATIO_BITS'($urandom));
      for (int k = 0; k < 110; k++) begin
        if (phase == 3 && k == 55) wait_for_results();
        issue_command(1'($urandom_range(0, 1)), random_velocity(), random_velocity(),
                      random_velocity(), enc_t'($urandom_range(0, 8191)));
      end
    end
  endtask

  // result side: random stall per item, then compare with the oldest prediction
  initial begin
    wheel_set_t want, got;
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = receiver_idle ? $urandom_range(0, 19) : 0;
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got.speed[0] = wheel0_rpm;
      got.speed[1] = wheel1_rpm;
      got.speed[2] = wheel2_rpm;
      got.speed[3] = wheel3_rpm;
      got.clip = clipped;
      if (expected_speeds.size() == 0) begin
        report_mismatch("wheel speeds with no command pending");
      end else begin
        want = expected_speeds.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.speed[i] !== want.speed[i])
            report_mismatch($sformatf("wheel%0d rpm %0d, expected %0d", i,
                                      $signed(got.speed[i]), $signed(want.speed[i])));
        end
        if (got.clip !== want.clip)
          report_mismatch($sformatf("clipped %b, expected %b", got.clip, want.clip));
      end
      @(negedge clk);
    end
  end

  // ends the run once no channel has moved an item for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = 1'b0;
    vel_x = '0;
    vel_y = '0;
    vel_w = '0;
    yaw_encoder = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_YAW_CENTER;
    cfg_data = '0;
    center_q = '0;
    arm_q = '0;
    ratio_q = '0;
    mismatches = 0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_config_masking();
    test_follow_extremes();
    test_rotation_quadrants();
    test_saturation();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
